### rtl/sadc_pkg.sv
package sadc_pkg;

  localparam int DATA_BITS_DEF = 16;
  localparam int VALUE_W       = 16;
  localparam int CTRL_W        = 8;
  localparam int CNT_W         = 5;
  localparam int S_TDATA_W     = 8;
  localparam int M_TDATA_W     = 24;

  // start, odd, upper half, middle pair, unipolar, single-ended, 1, 0
  localparam logic [CTRL_W-1:0] CTRL_BASE = 8'h8E;

  typedef struct packed {
    logic       strobe_pin;
    logic       dout_pin;
    logic [2:0] channel;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    logic               result_valid;
    logic               busy_res;
    logic               clock_enable;
    logic               serial_clock;
    logic               serial_data_out;
    logic               chip_select;
  } out_t;

  localparam int IN_W  = $bits(in_t);
  localparam int OUT_W = $bits(out_t);

  function automatic logic [CTRL_W-1:0] control_word(input logic [2:0] ch);
    logic [CTRL_W-1:0] w;
    w    = CTRL_BASE;
    w[6] = ch[0];
    w[5] = ch[2];
    w[4] = ch[1];
    return w;
  endfunction

endpackage

### rtl/serial_adc_channel_reader.sv
// Serial ADC channel reader: bit-banged master for an eight-channel serial ADC.
// Each slave word is one tick of pin activity: it carries the start request,
// the channel and the sampled dout and strobe pin levels. Each accepted word
// yields exactly one master word with the pin levels to drive for that tick
// (chip select, serial data, serial clock), the clock enable, a busy flag and,
// on the finish tick, result_valid with the sixteen-bit conversion value.
// A conversion shifts out an eight-bit control word (two ticks per bit), waits
// for the strobe pin, gives one clock pulse, then samples DATA_BITS data bits
// (two ticks per bit) MSB first.
// m_tvalid rises in the cycle after slave acceptance. Throughput is one word
// per cycle while the receiver takes each word; the single output register
// is refilled in the cycle it is taken. When the receiver stalls, s_tready
// drops until the output register is taken, and the sequencer holds its state.
// Reset clears the sequencer to idle, empties the output register and clears
// the armed register. cfg_we writes the armed register (clock_enable follows).
module serial_adc_channel_reader #(
  parameter int DATA_BITS = sadc_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // start_req, channel[2:0], dout_pin, strobe_pin, zero fill
  input  logic [sadc_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // chip_select, serial_data_out, serial_clock, clock_enable, busy_res,
  // result_valid, result_value[15:0], zero fill
  output logic [sadc_pkg::M_TDATA_W-1:0]   m_tdata
);

  logic           recorder_armed;
  logic           step;
  sadc_pkg::in_t  in_item;
  sadc_pkg::out_t out_item;
  sadc_pkg::out_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign in_item  = sadc_pkg::in_t'(s_tdata[sadc_pkg::IN_W-1:0]);

  sadc_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .in_item        (in_item),
    .recorder_armed (recorder_armed),
    .out_item       (out_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      recorder_armed <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        recorder_armed <= cfg_wdata;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= out_item;
    end
  end

  assign m_tdata = {{(sadc_pkg::M_TDATA_W - sadc_pkg::OUT_W){1'b0}}, out_reg};

endmodule

### rtl/sadc_seq.sv
module sadc_seq #(
  parameter int DATA_BITS = sadc_pkg::DATA_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  sadc_pkg::in_t  in_item,
  input  logic           recorder_armed,
  output sadc_pkg::out_t out_item
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_WAIT,
    PH_PULSE,
    PH_DATA,
    PH_FINISH
  } phase_t;

  phase_t                               phase, phase_next;
  logic [sadc_pkg::CNT_W-1:0]           bit_counter, bit_counter_next;
  logic [sadc_pkg::CTRL_W-1:0]          control_shift, control_shift_next;
  logic [sadc_pkg::VALUE_W-1:0]         data_shift, data_shift_next;
  logic                                 clock_level, clock_level_next;
  logic [sadc_pkg::CNT_W-1:0]           counter_inc;

  assign counter_inc = bit_counter + sadc_pkg::CNT_W'(1);

  always_comb begin
    phase_next         = phase;
    bit_counter_next   = bit_counter;
    control_shift_next = control_shift;
    data_shift_next    = data_shift;
    clock_level_next   = clock_level;
    out_item                 = '0;
    out_item.chip_select     = 1'b1;
    out_item.clock_enable    = recorder_armed;
    unique case (phase)
      PH_CMD: begin
        out_item.chip_select     = 1'b0;
        out_item.serial_data_out = control_shift[sadc_pkg::CTRL_W-1];
        if (!clock_level) begin
          clock_level_next = 1'b1;
        end else begin
          out_item.serial_clock = 1'b1;
          clock_level_next      = 1'b0;
          control_shift_next    = {control_shift[sadc_pkg::CTRL_W-2:0], 1'b0};
          bit_counter_next      = counter_inc;
          if (counter_inc >= sadc_pkg::CNT_W'(sadc_pkg::CTRL_W)) begin
            phase_next = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (in_item.strobe_pin) begin
          phase_next       = PH_PULSE;
          clock_level_next = 1'b0;
        end
      end
      PH_PULSE: begin
        out_item.chip_select = 1'b0;
        if (!clock_level) begin
          clock_level_next = 1'b1;
        end else begin
          out_item.serial_clock = 1'b1;
          clock_level_next      = 1'b0;
          bit_counter_next      = '0;
          data_shift_next       = '0;
          phase_next            = PH_DATA;
        end
      end
      PH_DATA: begin
        out_item.chip_select = 1'b0;
        if (!clock_level) begin
          data_shift_next  = {data_shift[sadc_pkg::VALUE_W-2:0], in_item.dout_pin};
          clock_level_next = 1'b1;
        end else begin
          out_item.serial_clock = 1'b1;
          clock_level_next      = 1'b0;
          bit_counter_next      = counter_inc;
          if (counter_inc >= sadc_pkg::CNT_W'(DATA_BITS)) begin
            phase_next = PH_FINISH;
          end
        end
      end
      PH_FINISH: begin
        out_item.result_valid = 1'b1;
        out_item.result_value = data_shift;
        phase_next            = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_item.start_req) begin
          control_shift_next   = sadc_pkg::control_word(in_item.channel);
          bit_counter_next     = '0;
          clock_level_next     = 1'b0;
          phase_next           = PH_CMD;
          out_item.chip_select = 1'b0;
        end
      end
    endcase
    out_item.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_counter   <= '0;
      control_shift <= '0;
      data_shift    <= '0;
      clock_level   <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_counter   <= bit_counter_next;
      control_shift <= control_shift_next;
      data_shift    <= data_shift_next;
      clock_level   <= clock_level_next;
    end
  end

  a_valid_cs_high: assert property (@(posedge clk) disable iff (rst)
    out_item.result_valid |-> out_item.chip_select && !out_item.busy_res)
    else $error("result word without chip select high");

  a_sclk_cs_low: assert property (@(posedge clk) disable iff (rst)
    out_item.serial_clock |-> !out_item.chip_select)
    else $error("serial clock pulse with chip select high");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_FINISH) |=> phase == PH_IDLE)
    else $error("finish did not return to idle");

  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(bit_counter) && $stable(data_shift))
    else $error("state moved without an accepted word");

endmodule

### verif/serial_adc_channel_reader_tb.sv
module serial_adc_channel_reader_tb;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_WAIT, PH_PULSE, PH_DATA, PH_FINISH
  } conv_phase_t;

  typedef struct {
    sadc_pkg::in_t  word;
    bit             typed;
    sadc_pkg::out_t pins;
  } plan_row_t;

  localparam int PLAN_ROWS   = 25;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic                           cfg_wdata = 1'b0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [sadc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [sadc_pkg::M_TDATA_W-1:0] m_tdata;

  // pin-level model of the sequencer
  conv_phase_t conv_phase  = PH_IDLE;
  logic [4:0]  bit_no      = '0;
  logic [7:0]  ctrl_bits   = '0;
  logic [15:0] sample_bits = '0;
  logic        half_level  = 1'b0;
  logic        armed_model = 1'b0;

  sadc_pkg::out_t expected_pins[$];
  plan_row_t      plan[PLAN_ROWS];
  int             words_in    = 0;
  int             err_count   = 0;
  int             dead_cycles = 0;
  int             hold_left   = 0;
  bit             hold_done   = 1'b0;

  wire holding = hold_left != 0;
  wire steady  = words_in >= 600 && words_in < 850;

  serial_adc_channel_reader #(.DATA_BITS(sadc_pkg::DATA_BITS_DEF)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic advance_pins(input sadc_pkg::in_t w, output sadc_pkg::out_t o);
    o = '0;
    o.chip_select = 1'b1;
    case (conv_phase)
      PH_CMD: begin
        o.chip_select     = 1'b0;
        o.serial_data_out = ctrl_bits[7];
        if (!half_level) begin
          half_level = 1'b1;
        end else begin
          o.serial_clock = 1'b1;
          half_level     = 1'b0;
          ctrl_bits      = ctrl_bits << 1;
          bit_no         = bit_no + 1'b1;
          if (bit_no >= 8) conv_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (w.strobe_pin) begin
          conv_phase = PH_PULSE;
          half_level = 1'b0;
        end
      end
      PH_PULSE: begin
        o.chip_select = 1'b0;
        if (!half_level) begin
          half_level = 1'b1;
        end else begin
          o.serial_clock = 1'b1;
          half_level     = 1'b0;
          bit_no         = '0;
          sample_bits    = '0;
          conv_phase     = PH_DATA;
        end
      end
      PH_DATA: begin
        o.chip_select = 1'b0;
        if (!half_level) begin
          sample_bits = {sample_bits[14:0], w.dout_pin};
          half_level  = 1'b1;
        end else begin
          o.serial_clock = 1'b1;
          half_level     = 1'b0;
          bit_no         = bit_no + 1'b1;
          if (bit_no >= sadc_pkg::DATA_BITS_DEF) conv_phase = PH_FINISH;
        end
      end
      PH_FINISH: begin
        o.result_valid = 1'b1;
        o.result_value = sample_bits;
        conv_phase     = PH_IDLE;
      end
      default: begin
        conv_phase = PH_IDLE;
        if (w.start_req) begin
          ctrl_bits     = {1'b1, w.channel[0], w.channel[2], w.channel[1], 4'b1110};
          bit_no        = '0;
          half_level    = 1'b0;
          conv_phase    = PH_CMD;
          o.chip_select = 1'b0;
        end
      end
    endcase
    o.clock_enable = armed_model;
    o.busy_res     = conv_phase != PH_IDLE;
  endtask

  task automatic send_word(input sadc_pkg::in_t w, input bit typed,
                           input sadc_pkg::out_t typed_pins);
    sadc_pkg::out_t pred;
    if (!steady && !holding && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(sadc_pkg::S_TDATA_W - sadc_pkg::IN_W){1'b0}}, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_pins(w, pred);
    expected_pins.push_back(typed ? typed_pins : pred);
    words_in++;
  endtask

  // hold the input until every expected word is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_armed(input logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    armed_model = v;
  endtask

  function automatic bit pins_differ(input sadc_pkg::out_t a, input sadc_pkg::out_t b);
    return a.chip_select !== b.chip_select || a.serial_data_out !== b.serial_data_out ||
           a.serial_clock !== b.serial_clock || a.clock_enable !== b.clock_enable ||
           a.busy_res !== b.busy_res || a.result_valid !== b.result_valid ||
           a.result_value !== b.result_value;
  endfunction

  task automatic note_mismatch(input string why, input sadc_pkg::out_t want,
                               input sadc_pkg::out_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, why, want, got);
  endtask

  always @(posedge clk) begin : check_out
    sadc_pkg::out_t got;
    sadc_pkg::out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[sadc_pkg::OUT_W-1:0];
      if (expected_pins.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_pins.pop_front();
        if (pins_differ(want, got)) note_mismatch("word mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_in >= 350) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      dead_cycles <= 0;
    end else begin
      dead_cycles <= dead_cycles + 1;
      if (dead_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sadc_pkg::in_t  w;
    sadc_pkg::out_t idle_pins;
    sadc_pkg::out_t start_pins;
    int             n;
    int             drought;

    idle_pins               = '0;
    idle_pins.chip_select   = 1'b1;
    idle_pins.clock_enable  = 1'b1;
    start_pins              = '0;
    start_pins.clock_enable = 1'b1;
    start_pins.busy_res     = 1'b1;

    plan[0] = '{word: '{strobe_pin: 1, dout_pin: 1, channel: 7, start_req: 0},
                typed: 1, pins: idle_pins};
    plan[1] = '{word: '{strobe_pin: 0, dout_pin: 0, channel: 0, start_req: 0},
                typed: 1, pins: idle_pins};
    plan[2] = '{word: '{strobe_pin: 0, dout_pin: 0, channel: 7, start_req: 1},
                typed: 1, pins: start_pins};
    // start requests while shifting the control word must be ignored
    for (int i = 3; i < 19; i++)
      plan[i] = '{word: '{strobe_pin: 1, dout_pin: i[0], channel: i[2:0], start_req: 1},
                  typed: 0, pins: '0};
    for (int i = 19; i < PLAN_ROWS; i++)
      plan[i] = '{word: '{strobe_pin: i >= 21, dout_pin: 1, channel: 5, start_req: i[0]},
                  typed: 0, pins: '0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_armed(1'b1);
    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].pins);

    drought = 0;
    for (int ph = 0; ph < 3; ph++) begin
      write_armed(ph == 1);
      n = 0;
      while (n < 275) begin
        if (drought == 0 && $urandom_range(99) == 0) drought = $urandom_range(60, 20);
        w.start_req  = 1'($urandom_range(1));
        w.channel    = 3'($urandom_range(7));
        w.dout_pin   = 1'($urandom_range(1));
        w.strobe_pin = (drought != 0) ? 1'b0 : ($urandom_range(3) == 0);
        if (drought != 0) drought--;
        send_word(w, 1'b0, '0);
        n++;
      end
    end

    settle();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### serial_adc_channel_reader.f
rtl/sadc_pkg.sv
rtl/sadc_seq.sv
rtl/serial_adc_channel_reader.sv
verif/serial_adc_channel_reader_tb.sv
